@@ hw/rtl/mme_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg
// shared constants, codes and types of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int POS_W     = 3;
  localparam int MODE_W    = 2;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // derived widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A  = 2'd0,
    MODE_WR_B  = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             zero;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last_elem;
  } beat_tag_t;

  typedef struct packed {
    logic      valid;
    beat_tag_t tag;
  } beat_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic [DATA_W-1:0] sum;
    logic              sat;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/mme_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme channel interfaces
// valid/ready channels for load/start words, result words and config writes
// ----------------------------------------------------------------------------
interface mme_in_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         row_index;
  logic [POS_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element;

  modport source (output valid, mode, row_index, col_index, element, input ready);
  modport sink   (input valid, mode, row_index, col_index, element, output ready);
endinterface

interface mme_out_if;
  import mme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] product_sum;
  logic                     saturated;
  logic                     last;

  modport source (output valid, out_row, out_col, product_sum, saturated, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_sum, saturated, last,
                  output ready);
endinterface

interface mme_cfg_if;
  import mme_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [DIM_W-1:0]     wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink   (input valid, wr_index, wr_data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/matrix_multiply_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// signed q16.16 matrix multiply over two element stores
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries load and start words. a load word (mode 0 for A, 1 for B)
//   writes one element at row/col and is taken one per cycle while idle.
//   a start word (mode 2) walks the stores and emits every C[i][j] on out_ch
//   in row-major order, with position, saturation flag and last marker.
//   cfg_ch writes rows_a, inner_dim and cols_b; it is always ready.
// sequencing:
//   each result takes max(inner_dim,1) store reads, then passes the read,
//   multiply and accumulate stages and the output register before the
//   next element starts; the reads are serial since each store has a single
//   read port. in_ch is not ready until the whole matrix has been handed
//   to the output register.
// stall:
//   a new element is started only when the output register is free or
//   being taken, so a stalled receiver just holds the sequencer waiting.
// reset:
//   rst_n is synchronous, active low; dimensions return to 8, the stores
//   keep their content and are undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_top
  import mme_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mme_in_if.sink    in_ch,
  mme_out_if.source out_ch,
  mme_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic [DIM_W-1:0] rows_a_r;
  logic [DIM_W-1:0] inner_dim_r;
  logic [DIM_W-1:0] cols_b_r;
  dims_t            dims;

  // input word decode
  logic          in_acc;
  logic          in_range;
  logic          we_a;
  logic          we_b;
  logic          start;
  logic [AW-1:0] wr_addr;

  // sequencer and datapath
  logic              busy;
  beat_t             beat;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     b_addr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  result_t           res;
  logic              out_free;

  // output register
  logic              out_valid_r;
  logic [POS_W-1:0]  out_row_r;
  logic [POS_W-1:0]  out_col_r;
  logic [DATA_W-1:0] out_sum_r;
  logic              out_sat_r;
  logic              out_last_r;

  // clamp a dimension to the store size
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (32'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  // config writes, index past the list is dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(MAX_DIM);
      inner_dim_r <= DIM_W'(MAX_DIM);
      cols_b_r    <= DIM_W'(MAX_DIM);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.wr_index)
        REG_ROWS_A:    rows_a_r    <= cfg_ch.wr_data;
        REG_INNER_DIM: inner_dim_r <= cfg_ch.wr_data;
        REG_COLS_B:    cols_b_r    <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  assign dims.nr = eff_dim(rows_a_r);
  assign dims.nk = eff_dim(inner_dim_r);
  assign dims.nc = eff_dim(cols_b_r);

  // input words only while the sequencer is idle, so store writes never
  // overlap the reads of a running multiply
  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = (32'(in_ch.row_index) < MAX_DIM) && (32'(in_ch.col_index) < MAX_DIM);
  assign we_a        = in_acc && in_range && (in_ch.mode == MODE_WR_A);
  assign we_b        = in_acc && in_range && (in_ch.mode == MODE_WR_B);
  assign start       = in_acc && (in_ch.mode == MODE_START);
  assign wr_addr     = AW'(in_ch.row_index) * AW'(MAX_DIM) + AW'(in_ch.col_index);

  mme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (in_ch.element),
    .re    (beat.valid),
    .raddr (a_addr),
    .rdata (a_data)
  );

  mme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (in_ch.element),
    .re    (beat.valid),
    .raddr (b_addr),
    .rdata (b_data)
  );

  mme_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dims     (dims),
    .out_free (out_free),
    .res_load (res.valid),
    .busy     (busy),
    .beat     (beat),
    .a_addr   (a_addr),
    .b_addr   (b_addr)
  );

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .a_data (a_data),
    .b_data (b_data),
    .res    (res)
  );

  // output register, loaded only when the sequencer saw it free
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid) begin
      out_row_r  <= POS_W'(res.row);
      out_col_r  <= POS_W'(res.col);
      out_sum_r  <= res.sum;
      out_sat_r  <= res.sat;
      out_last_r <= res.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_row     = out_row_r;
  assign out_ch.out_col     = out_col_r;
  assign out_ch.product_sum = out_sum_r;
  assign out_ch.saturated   = out_sat_r;
  assign out_ch.last        = out_last_r;

  // a result never lands on a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || $past(out_ch.ready)))
    else $error("result loaded over a pending output word");

  // store reads and input writes never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid |-> !in_acc)
    else $error("store read while an input word is taken");

  // the last element of a matrix returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.last) |=> !busy)
    else $error("sequencer busy after last element");

  // a clipped word holds one of the two range limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_sum_r == SAT_MAX || out_sum_r == SAT_MIN))
    else $error("saturated word outside range limits");

endmodule
`default_nettype wire

@@ hw/rtl/mme_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mme_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_mac
// multiply-accumulate pipeline with shift and saturation of the dot product
// ----------------------------------------------------------------------------
module mme_mac
  import mme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire beat_t             beat,
  input  wire logic [DATA_W-1:0] a_data,
  input  wire logic [DATA_W-1:0] b_data,
  output      result_t           res
);

  // stage 1: aligned with ram read data
  logic      valid1_r;
  beat_tag_t tag1_r;
  // stage 2: product
  logic                     valid2_r;
  beat_tag_t                tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_full;
  // stage 3: accumulator
  logic                    valid3_r;
  beat_tag_t               tag3_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] prod_ext;

  logic signed [DATA_W-1:0] a_s;
  logic signed [DATA_W-1:0] b_s;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    upper;
  logic                     fits;

  assign a_s       = $signed(a_data);
  assign b_s       = $signed(b_data);
  // full signed product, kept apart so both operands stay sign extended
  assign prod_full = a_s * b_s;
  assign prod_nxt  = tag1_r.zero ? '0 : prod_full;
  assign prod_ext  = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt   = tag2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid1_r <= beat.valid;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r && tag2_r.last_k;
    end
    if (beat.valid) begin
      tag1_r <= beat.tag;
    end
    if (valid1_r) begin
      tag2_r <= tag1_r;
      prod_r <= prod_nxt;
    end
    if (valid2_r) begin
      tag3_r <= tag2_r;
      acc_r  <= acc_nxt;
    end
  end

  // floor shift, then clip to the result range
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    res.valid = valid3_r;
    res.row   = tag3_r.row;
    res.col   = tag3_r.col;
    res.last  = tag3_r.last_elem;
    res.sat   = !fits;
    if (fits) begin
      res.sum = shifted[DATA_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      res.sum = SAT_MIN;
    end else begin
      res.sum = SAT_MAX;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mme_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_seq
// walks rows, columns and the inner index, issuing store reads per element
// ----------------------------------------------------------------------------
module mme_seq
  import mme_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire dims_t         dims,
  input  wire logic          out_free,
  input  wire logic          res_load,
  output      logic          busy,
  output      beat_t         beat,
  output      logic [AW-1:0] a_addr,
  output      logic [AW-1:0] b_addr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT_OUT,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] k_r;

  logic [DIM_W-1:0] nr_m1;
  logic [DIM_W-1:0] nk_m1;
  logic [DIM_W-1:0] nc_m1;
  logic             last_i;
  logic             last_j;
  logic             last_k;
  logic             zero_k;

  assign nr_m1  = dims.nr - DIM_W'(1);
  assign nk_m1  = dims.nk - DIM_W'(1);
  assign nc_m1  = dims.nc - DIM_W'(1);
  assign last_i = (DIM_W'(i_r) == nr_m1);
  assign last_j = (DIM_W'(j_r) == nc_m1);
  assign zero_k = (dims.nk == '0);
  assign last_k = zero_k || (DIM_W'(k_r) == nk_m1);

  assign busy   = (state_r != ST_IDLE);
  assign a_addr = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_addr = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);

  always_comb begin
    beat.valid         = (state_r == ST_ISSUE);
    beat.tag.first     = (k_r == '0);
    beat.tag.last_k    = last_k;
    beat.tag.zero      = zero_k;
    beat.tag.row       = i_r;
    beat.tag.col       = j_r;
    beat.tag.last_elem = last_i && last_j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start && (dims.nr != '0) && (dims.nc != '0)) begin
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            state_r <= ST_WAIT_OUT;
          end
        end
        ST_WAIT_OUT: begin
          if (out_free) begin
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (last_k) begin
            k_r     <= '0;
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (res_load) begin
            if (last_i && last_j) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_WAIT_OUT;
              if (last_j) begin
                j_r <= '0;
                i_r <= i_r + CNT_W'(1);
              end else begin
                j_r <= j_r + CNT_W'(1);
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/mme_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mme_tb_pkg
// product tracker for the matrix multiply engine: shadow stores, dimension
// registers and the queue of result words still owed by the engine
// ----------------------------------------------------------------------------
package mme_tb_pkg;
  import mme_pkg::*;

  // mode code that the engine leaves alone
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // wide enough for eight full-scale products
  localparam int ACC_TB_W = 2 * DATA_W + 6;
  localparam logic signed [ACC_TB_W-1:0] Q_MAX = 2147483647;
  localparam logic signed [ACC_TB_W-1:0] Q_MIN = -Q_MAX - 1;

  typedef struct {
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DATA_W-1:0] sum;
    logic                     sat;
    logic                     last;
  } c_elem_t;

  function automatic int clamp_dim(logic [DIM_W-1:0] d);
    if (d > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  class gemm_tracker;
    logic signed [DATA_W-1:0] a_mat [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] b_mat [MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0]         dim_rows;
    logic [DIM_W-1:0]         dim_inner;
    logic [DIM_W-1:0]         dim_cols;
    c_elem_t                  c_elems_due [$];
    int errors, n_loads, n_starts, n_ignored, n_cfg, n_results, n_sat;

    function new();
      dim_rows  = DIM_W'(MAX_DIM);
      dim_inner = DIM_W'(MAX_DIM);
      dim_cols  = DIM_W'(MAX_DIM);
    endfunction

    function void set_dim(reg_idx_t idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_ROWS_A:    dim_rows  = val;
        REG_INNER_DIM: dim_inner = val;
        REG_COLS_B:    dim_cols  = val;
        default: ;
      endcase
      n_cfg++;
    endfunction

    // one element of C: exact sum, floor shift, clip to q16.16
    function c_elem_t c_element(int i, int j, int nk, bit is_last);
      logic signed [ACC_TB_W-1:0] acc;
      logic signed [ACC_TB_W-1:0] shifted;
      logic signed [2*DATA_W-1:0] prod;
      c_elem_t e;
      int k;
      acc = '0;
      for (k = 0; k < nk; k++) begin
        prod = a_mat[i][k] * b_mat[k][j];
        acc  = acc + prod;
      end
      shifted = acc >>> FRAC_BITS;
      e.row  = POS_W'(i);
      e.col  = POS_W'(j);
      e.last = is_last;
      if (shifted > Q_MAX) begin
        e.sum = SAT_MAX;
        e.sat = 1'b1;
      end else if (shifted < Q_MIN) begin
        e.sum = SAT_MIN;
        e.sat = 1'b1;
      end else begin
        e.sum = shifted[DATA_W-1:0];
        e.sat = 1'b0;
      end
      return e;
    endfunction

    // accepted input word
    function void take_word(logic [MODE_W-1:0] m, logic [POS_W-1:0] r,
                            logic [POS_W-1:0] c, logic signed [DATA_W-1:0] v);
      int nr, nk, nc, i, j;
      case (m)
        MODE_WR_A: begin
          a_mat[r][c] = v;
          n_loads++;
        end
        MODE_WR_B: begin
          b_mat[r][c] = v;
          n_loads++;
        end
        MODE_START: begin
          nr = clamp_dim(dim_rows);
          nk = clamp_dim(dim_inner);
          nc = clamp_dim(dim_cols);
          for (i = 0; i < nr; i++)
            for (j = 0; j < nc; j++)
              c_elems_due.push_back(c_element(i, j, nk, i == nr - 1 && j == nc - 1));
          n_starts++;
        end
        default: n_ignored++;
      endcase
    endfunction

    // accepted result word against the oldest owed element
    function void check_c_elem(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                               logic signed [DATA_W-1:0] sum, logic sat, logic last);
      c_elem_t want;
      if (c_elems_due.size() == 0) begin
        $error("result word row %0d col %0d arrived with nothing owed", row, col);
        errors++;
        return;
      end
      want = c_elems_due.pop_front();
      n_results++;
      if (want.sat) n_sat++;
      if (row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, row);
        errors++;
      end
      if (col !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, col);
        errors++;
      end
      if (sum !== want.sum) begin
        $error("product_sum: expected %0d, got %0d", want.sum, sum);
        errors++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0d, got %0d", want.sat, sat);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/matrix_multiply_engine_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top_test
// drives load, start and config words into the matrix multiply engine and
// checks every emitted C element against a shadow of both stores; bursty
// sender, patterned receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module matrix_multiply_engine_top_test;
  import mme_pkg::*;
  import mme_tb_pkg::*;

  localparam int RANDOM_WORDS  = 80;
  localparam int SETTLE_CYCLES = 24;      // wind-down time for a start that owes nothing
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int TIME_LIMIT_NS = 20_000_000;

  // receiver stall patterns
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_style_t;

  logic clk;
  logic rst_n;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();
  mme_cfg_if cfg_ch ();

  matrix_multiply_engine_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gemm_tracker tracker = new();

  // which store entries hold a written value; nothing unwritten is ever read
  bit a_set [MAX_DIM][MAX_DIM];
  bit b_set [MAX_DIM][MAX_DIM];

  // effective dimensions of the current setting
  int cur_nr, cur_nk, cur_nc;

  int burst_left;     // words left in the current sender burst
  int holds_asked;    // long hold-offs requested from the receiver
  int dim_settings;

  // 20 ns clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the engine hangs
  initial begin : watchdog
    #(TIME_LIMIT_NS);
    $display("timeout: result words still owed: %0d", tracker.c_elems_due.size());
    $display("Some tests failed");
    $finish;
  end

  // mix of full-scale corners, random bit patterns and small q16.16 values
  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return SAT_MIN;
      1:       return SAT_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return $urandom;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // one input word; valid stays high across a burst and drops only in the gaps
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] r,
                           input logic [POS_W-1:0] c, input logic signed [DATA_W-1:0] v);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long burst with no idling
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.row_index <= r;
    in_ch.col_index <= c;
    in_ch.element   <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_word(m, r, c, v);
  endtask

  task automatic load_elem(input mode_t m, input int r, input int c,
                           input logic signed [DATA_W-1:0] v);
    send_word(m, POS_W'(r), POS_W'(c), v);
    if (m == MODE_WR_A) a_set[r][c] = 1'b1;
    else                b_set[r][c] = 1'b1;
  endtask

  // fill whatever the current dimensions read but was never written, then start
  task automatic start_product(input bit long_hold);
    int i, j, k;
    for (i = 0; i < cur_nr; i++)
      for (k = 0; k < cur_nk; k++)
        if (!a_set[i][k]) load_elem(MODE_WR_A, i, k, rand_q16());
    if (cur_nr > 0 && cur_nc > 0)
      for (k = 0; k < cur_nk; k++)
        for (j = 0; j < cur_nc; j++)
          if (!b_set[k][j]) load_elem(MODE_WR_B, k, j, rand_q16());
    if (long_hold) holds_asked++;
    // row, col and element are don't-care on a start word
    send_word(MODE_START, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
              $urandom);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DIM_W-1:0] val);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.wr_index <= idx;
    cfg_ch.wr_data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    tracker.set_dim(idx, val);
  endtask

  // only called with the engine idle
  task automatic write_dims(input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nk,
                            input logic [DIM_W-1:0] nc);
    cfg_write(REG_ROWS_A, nr);
    cfg_write(REG_INNER_DIM, nk);
    cfg_write(REG_COLS_B, nc);
    cfg_ch.valid <= 1'b0;
    cur_nr = clamp_dim(nr);
    cur_nk = clamp_dim(nk);
    cur_nc = clamp_dim(nc);
    dim_settings++;
  endtask

  // wait for every owed word, then for a start that owes nothing to wind down
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.c_elems_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: checks every accepted result word and drives ready
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_style_t style;
    int span, hold_left, holds_done, tick;
    span       = 0;
    hold_left  = 0;
    holds_done = 0;
    tick       = 0;
    style      = SINK_OPEN;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_c_elem(out_ch.out_row, out_ch.out_col, out_ch.product_sum,
                             out_ch.saturated, out_ch.last);
      // a requested hold-off is counted out here while the sender keeps going
      if (hold_left == 0 && holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        style = sink_style_t'($urandom_range(0, 3));
        span  = $urandom_range(32, 200);
      end
      span--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          SINK_OPEN:     out_ch.ready <= 1'b1;
          SINK_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
          SINK_PERIODIC: out_ch.ready <= (tick % 5) < 2;
          default:       out_ch.ready <= 1'b1;
        endcase
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [DIM_W-1:0] fixed_nr [4];
    logic [DIM_W-1:0] fixed_nk [4];
    logic [DIM_W-1:0] fixed_nc [4];
    logic [DIM_W-1:0] nr, nk, nc;
    int phase, seq, word_goal;

    // extreme shapes first: wide result, deep inner sum, values above MAX_DIM
    fixed_nr = '{4'd8, 4'd1, 4'd2, 4'd15};
    fixed_nk = '{4'd1, 4'd8, 4'd15, 4'd1};
    fixed_nc = '{4'd8, 4'd1, 4'd1, 4'd3};

    burst_left   = 0;
    holds_asked  = 0;
    dim_settings = 0;
    cur_nr = MAX_DIM;
    cur_nk = MAX_DIM;
    cur_nc = MAX_DIM;

    // every input known from time zero
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_WR_A;
    in_ch.row_index  <= '0;
    in_ch.col_index  <= '0;
    in_ch.element    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.wr_index  <= REG_ROWS_A;
    cfg_ch.wr_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: 2x2 corners ----
    write_dims(4'd2, 4'd2, 4'd2);
    load_elem(MODE_WR_A, 0, 0, SAT_MIN);
    load_elem(MODE_WR_A, 0, 1, SAT_MIN);
    load_elem(MODE_WR_A, 1, 0, -1);
    load_elem(MODE_WR_A, 1, 1, SAT_MAX);
    load_elem(MODE_WR_B, 0, 0, SAT_MIN);
    load_elem(MODE_WR_B, 1, 0, SAT_MIN);
    load_elem(MODE_WR_B, 0, 1, 1);
    load_elem(MODE_WR_B, 1, 1, 0);
    // C00 clips high, C10 clips low, C01 is exact, C11 floors -1 lsb of the product to -1 lsb
    start_product(1'b0);
    // unused mode must leave the stores alone
    send_word(MODE_UNUSED, 3'd7, 3'd7, 32'sh5A5A_5A5A);
    start_product(1'b0);
    // far corner of both stores
    load_elem(MODE_WR_A, 7, 7, SAT_MAX);
    load_elem(MODE_WR_B, 7, 7, SAT_MIN);

    // empty inner sum gives zeros, empty row or column count gives nothing
    settle();
    write_dims(4'd2, 4'd0, 4'd2);
    start_product(1'b0);
    settle();
    write_dims(4'd0, 4'd3, 4'd3);
    start_product(1'b0);
    settle();
    write_dims(4'd3, 4'd3, 4'd0);
    start_product(1'b0);

    // ---- random: load sequences closed by a start, some noise ----
    word_goal = tracker.n_loads + tracker.n_starts + RANDOM_WORDS;
    phase = 0;
    while (tracker.n_loads + tracker.n_starts < word_goal) begin
      if (phase < 4) begin
        nr = fixed_nr[phase];
        nk = fixed_nk[phase];
        nc = fixed_nc[phase];
      end else begin
        // mostly small shapes, now and then anything the register holds
        nr = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                         : DIM_W'($urandom_range(1, 4));
        nk = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                         : DIM_W'($urandom_range(1, 4));
        nc = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 15))
                                         : DIM_W'($urandom_range(1, 4));
      end
      settle();
      write_dims(nr, nk, nc);
      seq = 0;
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 9) == 0)
            send_word(MODE_UNUSED, POS_W'($urandom_range(0, 7)),
                      POS_W'($urandom_range(0, 7)), $urandom);
          else
            load_elem($urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A,
                      $urandom_range(0, 7), $urandom_range(0, 7), rand_q16());
        end
        // 8x8 result with the receiver held off: the engine backs up into in_ch
        start_product(phase == 0 && seq == 0);
        seq++;
      end
      phase++;
    end

    settle();
    $display("covered %0d load, %0d start and %0d unused-mode words, %0d dim settings",
             tracker.n_loads, tracker.n_starts, tracker.n_ignored, dim_settings);
    $display("checked %0d result words, %0d of them clipped, %0d config writes",
             tracker.n_results, tracker.n_sat, tracker.n_cfg);
    if (tracker.errors == 0 && tracker.c_elems_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ matrix_multiply_engine_top.f @@
hw/rtl/mme_pkg.sv
hw/rtl/mme_ifs.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_mac.sv
hw/rtl/mme_seq.sv
hw/rtl/matrix_multiply_engine_top.sv
tb/mme_tb_pkg.sv
tb/matrix_multiply_engine_top_test.sv
